### src/md_clb_pkg.sv
// shared constants, types and request codes for the cell list binning core
package md_clb_pkg;

    localparam int GRID_WIDTH    = 8;
    localparam int MAX_PARTICLES = 1024;
    localparam int NUM_CELLS     = GRID_WIDTH * GRID_WIDTH * GRID_WIDTH;

    // field widths
    localparam int PIDX_W = 11;
    localparam int CELL_W = 10;
    localparam int POS_W  = 32;
    localparam int INV_W  = 24;

    // memory address widths
    localparam int PA_W = $clog2(MAX_PARTICLES + 1);
    localparam int CA_W = $clog2(NUM_CELLS + 1);

    // scaling arithmetic
    localparam int PROD_W  = POS_W + INV_W + 1;
    localparam int Q_W     = PROD_W - 32;
    localparam int COORD_W = (GRID_WIDTH > 2) ? $clog2(GRID_WIDTH) : 1;

    localparam logic signed [Q_W-1:0] Q_LO = Q_W'(-(GRID_WIDTH / 2));
    localparam logic signed [Q_W-1:0] Q_HI = Q_W'(GRID_WIDTH - GRID_WIDTH / 2);

    localparam logic [INV_W-1:0] INV_RESET = INV_W'(65536);

    // request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QP_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        REQ_PLACE = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_HEAD  = 2'd2,
        REQ_NEXT  = 2'd3
    } t_req;

    typedef struct packed {
        t_req              req;
        logic              pidx_ok;
        logic [PIDX_W-1:0] pidx;
        logic              oog;
        logic [CELL_W-1:0] dest_cell;
        logic              cq_ok;
        logic [CELL_W-1:0] cq;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

endpackage

### src/md_cell_list_binning_core.sv
// a request passes the front stage register and the queue; the list engine
// reads its memories on the pop, steps eval, link (relink), fixp (new cell
// not empty) and done; a clear sweeps all memories. Its reads and writes go
// in sequence (one write port per memory), so it pops only after done
// reset: a clearing pass zeroes all memories, o_stall held high;
// the cell size register resets to 1.0
module md_cell_list_binning_core
    import md_clb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [INV_W-1:0]         i_cfg_wdata,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_req_type,
    input  logic [PIDX_W-1:0]        i_particle_index,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic [CELL_W-1:0]        i_cell_query,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [CELL_W-1:0]        o_cell_number,
    output logic [CELL_W-1:0]        o_previous_cell,
    output logic                     o_moved,
    output logic                     o_out_of_grid,
    output logic [PIDX_W-1:0]        o_read_value
);

    logic [INV_W-1:0] r_inv_cell_size;
    t_back_stat       back_stat;
    t_q_stat          q_stat;
    logic             push;
    logic             pop;
    t_cmd             push_cmd;
    t_cmd             head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_cell_size <= INV_RESET;
        end else if (i_cfg_we) begin
            r_inv_cell_size <= i_cfg_wdata;
        end
    end

    md_clb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_particle_index (i_particle_index),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_cell_query     (i_cell_query),
        .i_inv_cell_size  (r_inv_cell_size),
        .i_back_stat      (back_stat),
        .i_q_stat         (q_stat),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    md_clb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_head  (head_cmd)
    );

    md_clb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_stat        (q_stat),
        .i_head          (head_cmd),
        .o_pop           (pop),
        .o_stat          (back_stat),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cell_number   (o_cell_number),
        .o_previous_cell (o_previous_cell),
        .o_moved         (o_moved),
        .o_out_of_grid   (o_out_of_grid),
        .o_read_value    (o_read_value)
    );

endmodule

### src/md_clb_front.sv
// front end: takes requests, scales the position and classifies the cell
module md_clb_front
    import md_clb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_req_type,
    input  logic [PIDX_W-1:0]        i_particle_index,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    input  logic [CELL_W-1:0]        i_cell_query,
    input  logic [INV_W-1:0]         i_inv_cell_size,
    input  t_back_stat               i_back_stat,
    input  t_q_stat                  i_q_stat,
    output logic                     o_push,
    output t_cmd                     o_cmd
);

    typedef struct packed {
        logic               ok;
        logic [COORD_W-1:0] c;
    } t_coord;

    logic                     r_s1_valid;
    t_req                     r_req;
    logic [PIDX_W-1:0]        r_idx;
    logic [CELL_W-1:0]        r_cq;
    logic signed [PROD_W-1:0] r_prod_x;
    logic signed [PROD_W-1:0] r_prod_y;
    logic signed [PROD_W-1:0] r_prod_z;

    logic                     accept;
    t_coord                   cx;
    t_coord                   cy;
    t_coord                   cz;
    logic                     in_grid;
    logic [CELL_W-1:0]        cell_calc;

    // floor of the scaled coordinate is the top bits of the product
    function automatic t_coord f_bin(input logic signed [PROD_W-1:0] prod);
        logic signed [Q_W-1:0] q;
        logic [Q_W-1:0]        sh;
        t_coord                res;
        q      = prod[PROD_W-1 -: Q_W];
        sh     = q + Q_W'(GRID_WIDTH / 2);
        res.ok = (q >= Q_LO) && (q < Q_HI);
        res.c  = sh[COORD_W-1:0];
        return res;
    endfunction

    assign o_push  = r_s1_valid && !i_q_stat.full;
    assign o_stall = i_back_stat.init_busy || (r_s1_valid && i_q_stat.full);
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= t_req'(i_req_type);
            r_idx    <= i_particle_index;
            r_cq     <= i_cell_query;
            r_prod_x <= i_pos_x * $signed({1'b0, i_inv_cell_size});
            r_prod_y <= i_pos_y * $signed({1'b0, i_inv_cell_size});
            r_prod_z <= i_pos_z * $signed({1'b0, i_inv_cell_size});
        end
    end

    always_comb begin
        cx        = f_bin(r_prod_x);
        cy        = f_bin(r_prod_y);
        cz        = f_bin(r_prod_z);
        in_grid   = cx.ok && cy.ok && cz.ok;
        cell_calc = CELL_W'(1) + CELL_W'(cx.c) + CELL_W'(cy.c * GRID_WIDTH)
                  + CELL_W'(cz.c * GRID_WIDTH * GRID_WIDTH);

        o_cmd.req       = r_req;
        o_cmd.pidx      = r_idx;
        o_cmd.pidx_ok   = (r_idx >= PIDX_W'(1)) && (r_idx <= PIDX_W'(MAX_PARTICLES));
        o_cmd.oog       = !in_grid;
        o_cmd.dest_cell = in_grid ? cell_calc : '0;
        o_cmd.cq        = r_cq;
        o_cmd.cq_ok     = (r_cq >= CELL_W'(1)) && (r_cq <= CELL_W'(NUM_CELLS));
    end

endmodule

### src/md_clb_queue.sv
// short request queue between the front end and the list engine
module md_clb_queue
    import md_clb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output t_cmd    o_head
);

    t_cmd            r_entry [QDEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QC_W-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == QC_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QP_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QP_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QC_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### src/md_clb_back.sv
// list engine: head, link and cell memories, relink sequencer, result register
module md_clb_back
    import md_clb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_q_stat           i_q_stat,
    input  t_cmd              i_head,
    output logic              o_pop,
    output t_back_stat        o_stat,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CELL_W-1:0] o_cell_number,
    output logic [CELL_W-1:0] o_previous_cell,
    output logic              o_moved,
    output logic              o_out_of_grid,
    output logic [PIDX_W-1:0] o_read_value
);

    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_EVAL   = 7'b0000100,
        ST_LINK   = 7'b0001000,
        ST_FIXP   = 7'b0010000,
        ST_DONE   = 7'b0100000,
        ST_CLEAR  = 7'b1000000
    } t_state;

    logic [PIDX_W-1:0] mem_head [NUM_CELLS + 1];
    logic [PIDX_W-1:0] mem_next [MAX_PARTICLES + 1];
    logic [PIDX_W-1:0] mem_prev [MAX_PARTICLES + 1];
    logic [CELL_W-1:0] mem_cell [MAX_PARTICLES + 1];

    t_state            r_state;
    t_state            n_state;
    logic [PA_W-1:0]   r_sweep;
    t_cmd              r_cmd;
    logic [CELL_W-1:0] r_c_rd;
    logic [PIDX_W-1:0] r_n_rd;
    logic [PIDX_W-1:0] r_p_rd;
    logic [PIDX_W-1:0] r_h_rd;

    logic [CELL_W-1:0] r_res_cell;
    logic [CELL_W-1:0] r_res_prev;
    logic              r_res_moved;
    logic              r_res_oog;
    logic [PIDX_W-1:0] r_res_rv;

    logic              r_out_valid;
    logic [CELL_W-1:0] r_o_cell;
    logic [CELL_W-1:0] r_o_prev;
    logic              r_o_moved;
    logic              r_o_oog;
    logic [PIDX_W-1:0] r_o_rv;

    logic              sweeping;
    logic              sweep_last;
    logic              out_load;
    logic              place_go;
    logic              link_now;
    logic              unlink_now;

    logic [PA_W-1:0]   p_ra;
    logic [CA_W-1:0]   h_ra;

    logic              h_we;
    logic [CA_W-1:0]   h_wa;
    logic [PIDX_W-1:0] h_wd;
    logic              n_we;
    logic [PA_W-1:0]   n_wa;
    logic [PIDX_W-1:0] n_wd;
    logic              p_we;
    logic [PA_W-1:0]   p_wa;
    logic [PIDX_W-1:0] p_wd;
    logic              c_we;
    logic [PA_W-1:0]   c_wa;
    logic [CELL_W-1:0] c_wd;

    assign sweeping   = (r_state == ST_INIT) || (r_state == ST_CLEAR);
    assign sweep_last = (r_sweep == PA_W'(MAX_PARTICLES));
    assign o_pop      = (r_state == ST_IDLE) && !i_q_stat.empty;
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || !i_stall);
    assign o_stat.init_busy = (r_state == ST_INIT);

    assign place_go   = (r_cmd.req == REQ_PLACE) && r_cmd.pidx_ok && !r_cmd.oog;
    assign link_now   = ((r_state == ST_EVAL) && place_go && (r_c_rd == '0))
                      || (r_state == ST_LINK);
    assign unlink_now = (r_state == ST_EVAL) && place_go && (r_c_rd != '0)
                      && (r_c_rd != r_cmd.dest_cell);

    // read addresses come straight from the queue head
    always_comb begin
        p_ra = i_head.pidx_ok ? PA_W'(i_head.pidx) : '0;
        if (i_head.req == REQ_HEAD) begin
            h_ra = i_head.cq_ok ? CA_W'(i_head.cq) : '0;
        end else begin
            h_ra = CA_W'(i_head.dest_cell);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_head;
            r_c_rd <= mem_cell[p_ra];
            r_n_rd <= mem_next[p_ra];
            r_p_rd <= mem_prev[p_ra];
            r_h_rd <= mem_head[h_ra];
        end
    end

    // write ports, one write per memory per cycle, in list order
    always_comb begin
        h_we = 1'b0;
        h_wa = '0;
        h_wd = '0;
        n_we = 1'b0;
        n_wa = '0;
        n_wd = '0;
        p_we = 1'b0;
        p_wa = '0;
        p_wd = '0;
        c_we = 1'b0;
        c_wa = '0;
        c_wd = '0;
        if (sweeping) begin
            n_we = 1'b1;
            n_wa = r_sweep;
            p_we = 1'b1;
            p_wa = r_sweep;
            c_we = 1'b1;
            c_wa = r_sweep;
            h_we = (r_sweep <= PA_W'(NUM_CELLS));
            h_wa = CA_W'(r_sweep);
        end else if (unlink_now) begin
            // take the particle out of its old cell
            if (r_p_rd == '0) begin
                h_we = 1'b1;
                h_wa = CA_W'(r_c_rd);
                h_wd = r_n_rd;
            end else begin
                n_we = 1'b1;
                n_wa = PA_W'(r_p_rd);
                n_wd = r_n_rd;
            end
            if (r_n_rd != '0) begin
                p_we = 1'b1;
                p_wa = PA_W'(r_n_rd);
                p_wd = r_p_rd;
            end
        end else if (link_now) begin
            // push on the head of the new cell
            n_we = 1'b1;
            n_wa = PA_W'(r_cmd.pidx);
            n_wd = r_h_rd;
            p_we = 1'b1;
            p_wa = PA_W'(r_cmd.pidx);
            p_wd = '0;
            h_we = 1'b1;
            h_wa = CA_W'(r_cmd.dest_cell);
            h_wd = r_cmd.pidx;
            c_we = 1'b1;
            c_wa = PA_W'(r_cmd.pidx);
            c_wd = r_cmd.dest_cell;
        end else if (r_state == ST_FIXP) begin
            p_we = 1'b1;
            p_wa = PA_W'(r_h_rd);
            p_wd = r_cmd.pidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            mem_head[h_wa] <= h_wd;
        end
        if (n_we) begin
            mem_next[n_wa] <= n_wd;
        end
        if (p_we) begin
            mem_prev[p_wa] <= p_wd;
        end
        if (c_we) begin
            mem_cell[c_wa] <= c_wd;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (sweep_last) n_state = ST_IDLE;
            end
            ST_CLEAR: begin
                if (sweep_last) n_state = ST_DONE;
            end
            ST_IDLE: begin
                if (o_pop) begin
                    n_state = (i_head.req == REQ_CLEAR) ? ST_CLEAR : ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (link_now) begin
                    n_state = (r_h_rd != '0) ? ST_FIXP : ST_DONE;
                end else if (unlink_now) begin
                    n_state = ST_LINK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_LINK: begin
                n_state = (r_h_rd != '0) ? ST_FIXP : ST_DONE;
            end
            ST_FIXP: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (sweeping) begin
                r_sweep <= sweep_last ? '0 : r_sweep + PA_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result fields, zero for anything that does not apply
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res_cell  <= '0;
            r_res_prev  <= '0;
            r_res_moved <= 1'b0;
            r_res_oog   <= 1'b0;
            r_res_rv    <= '0;
        end else if (r_state == ST_EVAL) begin
            case (r_cmd.req)
                REQ_PLACE: begin
                    if (r_cmd.pidx_ok) begin
                        r_res_cell  <= r_cmd.dest_cell;
                        r_res_prev  <= r_c_rd;
                        r_res_moved <= unlink_now;
                        r_res_oog   <= r_cmd.oog;
                    end
                end
                REQ_HEAD: begin
                    r_res_rv <= r_cmd.cq_ok ? r_h_rd : '0;
                end
                REQ_NEXT: begin
                    r_res_rv <= r_cmd.pidx_ok ? r_n_rd : '0;
                end
                default: begin
                    r_res_rv <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_cell  <= r_res_cell;
            r_o_prev  <= r_res_prev;
            r_o_moved <= r_res_moved;
            r_o_oog   <= r_res_oog;
            r_o_rv    <= r_res_rv;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cell_number   = r_o_cell;
    assign o_previous_cell = r_o_prev;
    assign o_moved         = r_o_moved;
    assign o_out_of_grid   = r_o_oog;
    assign o_read_value    = r_o_rv;

endmodule
